// ===== hdl/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared field widths, request and status codes, and parameter defaults for
// the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int OP_W     = 2;
    localparam int PAGE_W   = 15;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 16;

    localparam logic [OP_W-1:0] OP_RELEASE   = OP_W'(0);
    localparam logic [OP_W-1:0] OP_MARK_USED = OP_W'(1);
    localparam logic [OP_W-1:0] OP_ALLOC     = OP_W'(2);

    localparam logic [STATUS_W-1:0] STATUS_DONE  = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_SAME  = STATUS_W'(2);

    localparam int DEF_NUM_PAGES = 32768;
    localparam int DEF_WORD_BITS = 32;

endpackage

// ===== hdl/bpfa_ram.sv =====
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/bpfa_find.sv =====
// ----------------------------------------------------------------------------
// bpfa_find
// Priority encoder: flags a nonzero vector and gives the index of its lowest
// set bit.
// ----------------------------------------------------------------------------
module bpfa_find #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]                              vec,
    output logic                                          any,
    output logic [((WIDTH > 1) ? $clog2(WIDTH) : 1)-1:0]  idx
);

    localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    always_comb
    begin
        idx = '0;
        for (int i = WIDTH - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                idx = IW'(i);
            end
        end
    end

    assign any = |vec;

endmodule

// ===== hdl/bitmap_page_frame_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page-frame allocator over a free bitmap held in RAM, with a
// summary RAM of nonempty words and a register of nonempty summary words.
// ----------------------------------------------------------------------------
// After reset the block sweeps both RAMs to zero, one word per cycle, over
// all NUM_PAGES / WORD_BITS bitmap words (1024 at the defaults); in_ready
// stays low until the sweep ends. The block then works on one request at a
// time and every request gives exactly one result. An out-of-range page, an
// unused opcode or an allocation with nothing free goes straight to the
// result; a release or mark-used reads the bitmap and summary words, then
// writes them back if the bit changes; an allocation first reads the summary
// word that picks the bitmap word. A result waits in the output register
// while the next request is already accepted, so the back side stalls only
// when that register is still full. WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
    parameter int NUM_PAGES = bpfa_pkg::DEF_NUM_PAGES,
    parameter int WORD_BITS = bpfa_pkg::DEF_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bpfa_pkg::OP_W-1:0]     op,
    input  logic [bpfa_pkg::PAGE_W-1:0]   page_number,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpfa_pkg::PAGE_W-1:0]   result_page,
    output logic [bpfa_pkg::STATUS_W-1:0] status,
    output logic [bpfa_pkg::FREE_W-1:0]   free_pages
);

    localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_WORDS = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_AW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SUM_AW    = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
    localparam logic [MAP_AW-1:0] CLR_LAST = MAP_AW'(MAP_WORDS - 1);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_CLEAR = ST_W'(0);
    localparam logic [ST_W-1:0] ST_IDLE  = ST_W'(1);
    localparam logic [ST_W-1:0] ST_SRD   = ST_W'(2);
    localparam logic [ST_W-1:0] ST_MOD   = ST_W'(3);
    localparam logic [ST_W-1:0] ST_PUSH  = ST_W'(4);

    logic [ST_W-1:0]               state_reg, state_next;
    logic [MAP_AW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [bpfa_pkg::OP_W-1:0]     op_reg, op_next;
    logic [bpfa_pkg::PAGE_W-1:0]   page_reg, page_next;
    logic [SUM_AW-1:0]             sidx_reg, sidx_next;
    logic [MAP_AW-1:0]             widx_reg, widx_next;
    logic [SUM_WORDS-1:0]          top_reg, top_next;
    logic [bpfa_pkg::FREE_W-1:0]   free_reg, free_next;
    logic [bpfa_pkg::PAGE_W-1:0]   res_page_reg, res_page_next;
    logic [bpfa_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic                          out_valid_reg, out_valid_next;
    logic [bpfa_pkg::PAGE_W-1:0]   out_page_reg, out_page_next;
    logic [bpfa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [bpfa_pkg::FREE_W-1:0]   out_free_reg, out_free_next;

    logic                  map_we, map_re, sum_we, sum_re;
    logic [MAP_AW-1:0]     map_waddr, map_raddr;
    logic [SUM_AW-1:0]     sum_waddr, sum_raddr;
    logic [WORD_BITS-1:0]  map_wdata, map_rdata, sum_wdata, sum_rdata;

    logic                  top_any, sum_any, map_any;
    logic [SUM_AW-1:0]     top_idx;
    logic [BIT_AW-1:0]     sum_bit_idx, map_bit_idx;

    logic [31:0]           page_wide;
    logic                  page_in_range;
    logic [MAP_AW-1:0]     req_widx, alloc_widx;
    logic [SUM_AW-1:0]     req_sidx;
    logic [BIT_AW-1:0]     bit_sel, sum_pos;
    logic                  is_free;
    logic [WORD_BITS-1:0]  new_word, new_sum;
    logic                  out_load;

    bpfa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    bpfa_ram #(.WIDTH(WORD_BITS), .DEPTH(SUM_WORDS)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    bpfa_find #(.WIDTH(SUM_WORDS)) u_find_top (
        .vec (top_reg),
        .any (top_any),
        .idx (top_idx)
    );

    bpfa_find #(.WIDTH(WORD_BITS)) u_find_sum (
        .vec (sum_rdata),
        .any (sum_any),
        .idx (sum_bit_idx)
    );

    bpfa_find #(.WIDTH(WORD_BITS)) u_find_map (
        .vec (map_rdata),
        .any (map_any),
        .idx (map_bit_idx)
    );

    assign in_ready      = (state_reg == ST_IDLE);
    assign page_wide     = 32'(page_number);
    assign page_in_range = (page_wide < 32'(NUM_PAGES));
    assign req_widx      = MAP_AW'(page_wide >> BIT_AW);
    assign req_sidx      = SUM_AW'(32'(req_widx) >> BIT_AW);
    assign alloc_widx    = MAP_AW'((32'(sidx_reg) << BIT_AW) | 32'(sum_bit_idx));
    assign bit_sel       = (op_reg == bpfa_pkg::OP_ALLOC) ? map_bit_idx
                                                          : BIT_AW'(32'(page_reg));
    assign sum_pos       = BIT_AW'(32'(widx_reg));
    assign is_free       = map_rdata[bit_sel];
    assign out_load      = (state_reg == ST_PUSH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        sidx_next       = sidx_reg;
        widx_next       = widx_reg;
        top_next        = top_reg;
        free_next       = free_reg;
        res_page_next   = res_page_reg;
        res_status_next = res_status_reg;
        map_we          = 1'b0;
        map_waddr       = widx_reg;
        map_wdata       = '0;
        map_re          = 1'b0;
        map_raddr       = req_widx;
        sum_we          = 1'b0;
        sum_waddr       = sidx_reg;
        sum_wdata       = '0;
        sum_re          = 1'b0;
        sum_raddr       = req_sidx;
        new_word        = map_rdata;
        new_sum         = sum_rdata;

        case (state_reg)
            ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_cnt_reg;
                sum_we    = 1'b1;
                sum_waddr = SUM_AW'(clr_cnt_reg);
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + MAP_AW'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next   = op;
                    page_next = page_number;
                    case (op)
                        bpfa_pkg::OP_ALLOC:
                        begin
                            if (top_any)
                            begin
                                sidx_next  = top_idx;
                                sum_re     = 1'b1;
                                sum_raddr  = top_idx;
                                state_next = ST_SRD;
                            end
                            else
                            begin
                                res_page_next   = '0;
                                res_status_next = bpfa_pkg::STATUS_EMPTY;
                                state_next      = ST_PUSH;
                            end
                        end
                        bpfa_pkg::OP_RELEASE, bpfa_pkg::OP_MARK_USED:
                        begin
                            if (page_in_range)
                            begin
                                widx_next  = req_widx;
                                sidx_next  = req_sidx;
                                map_re     = 1'b1;
                                sum_re     = 1'b1;
                                state_next = ST_MOD;
                            end
                            else
                            begin
                                res_page_next   = page_number;
                                res_status_next = bpfa_pkg::STATUS_SAME;
                                state_next      = ST_PUSH;
                            end
                        end
                        default:
                        begin
                            res_page_next   = page_number;
                            res_status_next = bpfa_pkg::STATUS_DONE;
                            state_next      = ST_PUSH;
                        end
                    endcase
                end
            end
            ST_SRD:
            begin
                widx_next  = alloc_widx;
                map_re     = 1'b1;
                map_raddr  = alloc_widx;
                sum_re     = 1'b1;
                sum_raddr  = sidx_reg;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                res_page_next = (op_reg == bpfa_pkg::OP_ALLOC)
                              ? bpfa_pkg::PAGE_W'((32'(widx_reg) << BIT_AW) | 32'(bit_sel))
                              : page_reg;
                if ((op_reg == bpfa_pkg::OP_RELEASE) == is_free)
                begin
                    res_status_next = bpfa_pkg::STATUS_SAME;
                end
                else
                begin
                    res_status_next   = bpfa_pkg::STATUS_DONE;
                    new_word[bit_sel] = (op_reg == bpfa_pkg::OP_RELEASE);
                    new_sum[sum_pos]  = |new_word;
                    map_we            = 1'b1;
                    map_wdata         = new_word;
                    sum_we            = 1'b1;
                    sum_wdata         = new_sum;
                    top_next[sidx_reg] = |new_sum;
                    free_next = (op_reg == bpfa_pkg::OP_RELEASE)
                              ? free_reg + bpfa_pkg::FREE_W'(1)
                              : free_reg - bpfa_pkg::FREE_W'(1);
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_page_next   = out_page_reg;
        out_status_next = out_status_reg;
        out_free_next   = out_free_reg;
        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_page_next   = res_page_reg;
            out_status_next = res_status_reg;
            out_free_next   = free_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            top_reg       <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            top_reg       <= top_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        page_reg       <= page_next;
        sidx_reg       <= sidx_next;
        widx_reg       <= widx_next;
        res_page_reg   <= res_page_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_status_reg <= out_status_next;
        out_free_reg   <= out_free_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_page = out_page_reg;
    assign status      = out_status_reg;
    assign free_pages  = out_free_reg;

    a_sum_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRD) |-> sum_any)
        else $error("summary word picked by allocation is empty");

    a_map_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD && op_reg == bpfa_pkg::OP_ALLOC) |-> map_any)
        else $error("bitmap word picked by allocation is empty");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_status_reg == bpfa_pkg::STATUS_EMPTY) |-> (free_reg == '0))
        else $error("no free page reported while free count is nonzero");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |=>
        ((free_reg == $past(free_reg)) == (res_status_reg == bpfa_pkg::STATUS_SAME)))
        else $error("free count change disagrees with request status");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(map_we && map_re))
        else $error("bitmap read and write in the same cycle");

endmodule
